// ----- src/pearson_row_correlation_assert.svh -----
// Assertion macros used by the correlation engine controller.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef PEARSON_ROW_CORRELATION_ASSERT_SVH
`define PEARSON_ROW_CORRELATION_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PRC_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PRC_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// ----- src/prc_pkg.sv -----
// ----------------------------------------------------------------------------
// Pearson row correlation package
// Sizes, codes and the command and status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package prc_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int DEPTH    = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W   = $clog2(DEPTH);

  localparam int IDX_W     = 6;
  localparam int SMP_W     = 16;
  localparam int LIM_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_W     = 8;

  // Accumulator and arithmetic widths (at most 64 columns are summed).
  localparam int SUM_W    = 23;
  localparam int SQ_W     = 38;
  localparam int X_W      = 39;
  localparam int MA_W     = 40;
  localparam int MB_W     = 24;
  localparam int MP_W     = MA_W + MB_W;
  localparam int V_W      = 46;
  localparam int MAG_W    = 44;
  localparam int PROD_W   = 2 * MAG_W;
  localparam int REM_W    = PROD_W + 1;
  localparam int Q_W      = 33;
  localparam int RT_ARG_W = Q_W + 1;
  localparam int ROOT_W   = 17;

  // Step counts of the sequenced phases.
  localparam int VAR_STEPS  = 7;
  localparam int MUL_STEPS  = MAG_W;
  localparam int DIV_STEPS  = Q_W;
  localparam int SQRT_STEPS = ROOT_W;

  typedef enum logic [0:0] {
    OPC_LOAD  = 1'b0,
    OPC_QUERY = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_VAR = 2'd1,
    ST_RANGE    = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLS = 2'd0,
    CFG_ROWS = 2'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    DP_IDLE,
    DP_WALK,
    DP_VAR,
    DP_MUL,
    DP_DIV,
    DP_SQRT
  } dp_op_e;

  typedef struct packed {
    logic             we;
    logic             capture;
    dp_op_e           op;
    logic             clr;
    logic [LIM_W-1:0] ncols;
  } cmd_t;

  typedef struct packed {
    logic                    last;
    logic                    var_zero;
    logic signed [SMP_W-1:0] corr;
  } stat_t;

endpackage

`default_nettype wire

// ----- src/pearson_row_correlation.sv -----
// ----------------------------------------------------------------------------
// Pearson row correlation engine
// A store of signed 16-bit samples, one row per signal, with queries that
// return the Pearson coefficient of two rows in signed Q1.15.
//
// Input beats are accepted when start_i is high and busy_o is low. A load
// (opcode 0) writes one sample in that cycle and gives no result. A query
// (opcode 1) gives one result beat on result_valid_o, held for one cycle.
// Out-of-range rows and the same row twice answer the cycle after accept.
// Other queries hold busy_o high through their phases in order: column walk,
// six shared-multiplier steps, two serial 44-bit multiplies, a restoring
// divider and a bit-serial root; the result beat follows in the next cycle.
// A zero variance ends the query after the shared-multiplier steps.
// busy_o is high for all of such a query; loads may come every idle cycle.
// Configuration writes on cfg_we_i take effect at once; register 0 is the
// column count, register 1 the row count, both 64 after reset.
// Reset returns the sequencer to idle; the sample memory is not cleared.
// The receiver cannot stall: each result beat must be taken when shown.
// ----------------------------------------------------------------------------
`default_nettype none

module pearson_row_correlation (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [0:0]                        opcode_i,
  input  logic [prc_pkg::IDX_W-1:0]         row_index_i,
  input  logic [prc_pkg::IDX_W-1:0]         col_index_i,
  input  logic signed [prc_pkg::SMP_W-1:0]  sample_value_i,
  input  logic [prc_pkg::IDX_W-1:0]         other_row_i,
  input  logic                              cfg_we_i,
  input  logic [prc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [prc_pkg::LIM_W-1:0]         cfg_data_i,
  output logic                              result_valid_o,
  output logic signed [prc_pkg::SMP_W-1:0]  correlation_o,
  output logic [1:0]                        status_o
);
  import prc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer, configuration and result registers.
  prc_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .opcode_i       (opcode_i),
    .row_index_i    (row_index_i),
    .col_index_i    (col_index_i),
    .other_row_i    (other_row_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_o          (cmd),
    .stat_i         (stat),
    .result_valid_o (result_valid_o),
    .correlation_o  (correlation_o),
    .status_o       (status_o)
  );

  // Memory and arithmetic.
  prc_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .row_index_i    (row_index_i),
    .col_index_i    (col_index_i),
    .other_row_i    (other_row_i),
    .sample_value_i (sample_value_i),
    .stat_o         (stat)
  );

endmodule

`default_nettype wire

// ----- src/prc_dp.sv -----
// ----------------------------------------------------------------------------
// Pearson row correlation datapath
// Sample memory, column walk with accumulators, variance products, serial
// multipliers, restoring divider and bit-serial square root.
// ----------------------------------------------------------------------------
`default_nettype none

module prc_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  prc_pkg::cmd_t                 cmd_i,
  input  logic [prc_pkg::IDX_W-1:0]     row_index_i,
  input  logic [prc_pkg::IDX_W-1:0]     col_index_i,
  input  logic [prc_pkg::IDX_W-1:0]     other_row_i,
  input  logic signed [prc_pkg::SMP_W-1:0] sample_value_i,
  output prc_pkg::stat_t                stat_o
);
  import prc_pkg::*;

  logic [SMP_W-1:0] mem [DEPTH];

  logic [IDX_W-1:0] row_a_q, row_b_q;
  logic [CNT_W-1:0] cnt_q;
  logic             rd_v_q, pv_q;
  logic signed [SMP_W-1:0] rd_a_q, rd_b_q, pa_q, pb_q;
  logic signed [2*SMP_W-1:0] paa_q, pbb_q, pab_q;
  logic signed [SUM_W-1:0] si_q, sj_q;
  logic signed [SQ_W:0]   sii_q, sjj_q;
  logic signed [X_W-1:0]  sij_q;
  logic signed [MP_W-1:0] mp_q;
  logic signed [V_W-1:0]  vi_q, vj_q, cov_q;
  logic [PROD_W-1:0] mc1_q, mc2_q, acc1_q, acc2_q;
  logic [MAG_W-1:0]  mr1_q, mr2_q;
  logic [REM_W-1:0]  rem_q;
  logic [Q_W-1:0]    q_q;
  logic [RT_ARG_W-1:0] num_q, res_q, one_q;

  logic             last, step, issue;
  logic [CNT_W-1:0] walk_end, ncols_w;
  logic [ADDR_W-1:0] addr_a, addr_b, wr_addr;
  logic signed [MA_W-1:0] ma;
  logic signed [MB_W-1:0] mb;
  logic signed [V_W-1:0]  cov_neg;
  logic [MAG_W-1:0]  mag;
  logic [REM_W-1:0]  div_ext, rem_diff;
  logic [RT_ARG_W-1:0] trial;
  logic [ROOT_W:0]   k_sum;
  logic [ROOT_W-1:0] k, k_neg;

  // Phase end detection from the shared step counter.
  always_comb begin
    ncols_w  = CNT_W'(cmd_i.ncols);
    walk_end = ncols_w + CNT_W'(2);
    unique case (cmd_i.op)
      DP_WALK: last = (cnt_q == walk_end);
      DP_VAR:  last = (cnt_q == CNT_W'(VAR_STEPS));
      DP_MUL:  last = (cnt_q == CNT_W'(MUL_STEPS));
      DP_DIV:  last = (cnt_q == CNT_W'(DIV_STEPS));
      DP_SQRT: last = (cnt_q == CNT_W'(SQRT_STEPS));
      default: last = 1'b0;
    endcase
    step  = !cmd_i.clr && !last && (cmd_i.op != DP_IDLE);
    issue = (cmd_i.op == DP_WALK) && step && (cnt_q < ncols_w);
  end

  assign addr_a  = ADDR_W'(int'(row_a_q) * MAX_COLS + int'(cnt_q));
  assign addr_b  = ADDR_W'(int'(row_b_q) * MAX_COLS + int'(cnt_q));
  assign wr_addr = ADDR_W'(int'(row_index_i) * MAX_COLS + int'(col_index_i));

  // Control registers: step counter and walk pipeline valids.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      rd_v_q <= 1'b0;
      pv_q   <= 1'b0;
    end else begin
      if (cmd_i.clr) begin
        cnt_q <= '0;
      end else if (step) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      rd_v_q <= issue;
      pv_q   <= rd_v_q;
    end
  end

  // Sample memory: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      mem[wr_addr] <= sample_value_i;
    end
    if (issue) begin
      rd_a_q <= mem[addr_a];
      rd_b_q <= mem[addr_b];
    end
  end

  // Query rows are captured when the query is accepted.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      row_a_q <= row_index_i;
      row_b_q <= other_row_i;
    end
  end

  // Column walk: products one stage after the read, sums one stage later.
  always_ff @(posedge clk_i) begin
    paa_q <= rd_a_q * rd_a_q;
    pbb_q <= rd_b_q * rd_b_q;
    pab_q <= rd_a_q * rd_b_q;
    pa_q  <= rd_a_q;
    pb_q  <= rd_b_q;
    if (cmd_i.clr && cmd_i.op == DP_WALK) begin
      si_q  <= '0;
      sj_q  <= '0;
      sii_q <= '0;
      sjj_q <= '0;
      sij_q <= '0;
    end else if (pv_q) begin
      si_q  <= si_q + SUM_W'(pa_q);
      sj_q  <= sj_q + SUM_W'(pb_q);
      sii_q <= sii_q + (SQ_W+1)'(paa_q);
      sjj_q <= sjj_q + (SQ_W+1)'(pbb_q);
      sij_q <= sij_q + X_W'(pab_q);
    end
  end

  // Shared multiplier operands for the variance and covariance terms.
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cnt_q)
      CNT_W'(0): begin ma = MA_W'(sii_q); mb = MB_W'({1'b0, cmd_i.ncols}); end
      CNT_W'(1): begin ma = MA_W'(si_q);  mb = MB_W'(si_q); end
      CNT_W'(2): begin ma = MA_W'(sjj_q); mb = MB_W'({1'b0, cmd_i.ncols}); end
      CNT_W'(3): begin ma = MA_W'(sj_q);  mb = MB_W'(sj_q); end
      CNT_W'(4): begin ma = MA_W'(sij_q); mb = MB_W'({1'b0, cmd_i.ncols}); end
      CNT_W'(5): begin ma = MA_W'(si_q);  mb = MB_W'(sj_q); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign cov_neg = -cov_q;
  assign mag     = cov_q[V_W-1] ? cov_neg[MAG_W-1:0] : cov_q[MAG_W-1:0];
  assign div_ext = {1'b0, acc1_q};
  assign rem_diff = rem_q - div_ext;
  assign trial   = res_q + one_q;

  // Variance, big products, division and root, one phase after another.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_VAR && step) begin
      mp_q <= ma * mb;
      unique case (cnt_q)
        CNT_W'(1): vi_q  <= V_W'(mp_q);
        CNT_W'(2): vi_q  <= vi_q - V_W'(mp_q);
        CNT_W'(3): vj_q  <= V_W'(mp_q);
        CNT_W'(4): vj_q  <= vj_q - V_W'(mp_q);
        CNT_W'(5): cov_q <= V_W'(mp_q);
        CNT_W'(6): cov_q <= cov_q - V_W'(mp_q);
        default: ;
      endcase
    end
    if (cmd_i.op == DP_MUL) begin
      if (cmd_i.clr) begin
        mc1_q  <= PROD_W'(vi_q[MAG_W-1:0]);
        mr1_q  <= vj_q[MAG_W-1:0];
        mc2_q  <= PROD_W'(mag);
        mr2_q  <= mag;
        acc1_q <= '0;
        acc2_q <= '0;
      end else if (step) begin
        if (mr1_q[0]) acc1_q <= acc1_q + mc1_q;
        if (mr2_q[0]) acc2_q <= acc2_q + mc2_q;
        mc1_q <= mc1_q << 1;
        mc2_q <= mc2_q << 1;
        mr1_q <= mr1_q >> 1;
        mr2_q <= mr2_q >> 1;
      end
    end
    if (cmd_i.op == DP_DIV) begin
      if (cmd_i.clr) begin
        rem_q <= {1'b0, acc2_q};
        q_q   <= '0;
      end else if (step) begin
        if (rem_q >= div_ext) begin
          rem_q <= {rem_diff[REM_W-2:0], 1'b0};
          q_q   <= {q_q[Q_W-2:0], 1'b1};
        end else begin
          rem_q <= {rem_q[REM_W-2:0], 1'b0};
          q_q   <= {q_q[Q_W-2:0], 1'b0};
        end
      end
    end
    if (cmd_i.op == DP_SQRT) begin
      if (cmd_i.clr) begin
        num_q <= {1'b0, q_q};
        res_q <= '0;
        one_q <= RT_ARG_W'(1) << (Q_W - 1);
      end else if (step) begin
        if (num_q >= trial) begin
          num_q <= num_q - trial;
          res_q <= (res_q >> 1) + one_q;
        end else begin
          res_q <= res_q >> 1;
        end
        one_q <= one_q >> 2;
      end
    end
  end

  // Round the root to the nearest Q1.15 magnitude and apply the sign.
  always_comb begin
    k_sum = {1'b0, res_q[ROOT_W-1:0]} + (ROOT_W+1)'(1);
    k     = k_sum[ROOT_W:1];
    k_neg = -k;
    stat_o.last     = last;
    stat_o.var_zero = (vi_q <= 0) || (vj_q <= 0);
    if (cov_q[V_W-1]) begin
      stat_o.corr = k_neg[SMP_W-1:0];
    end else if (k[SMP_W-1]) begin
      stat_o.corr = SMP_W'(16'sh7FFF);
    end else begin
      stat_o.corr = k[SMP_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- src/prc_ctrl.sv -----
// ----------------------------------------------------------------------------
// Pearson row correlation controller
// Configuration registers, range checks, phase sequencing and result beat.
// ----------------------------------------------------------------------------
`default_nettype none
`include "pearson_row_correlation_assert.svh"

module prc_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [0:0]                        opcode_i,
  input  logic [prc_pkg::IDX_W-1:0]         row_index_i,
  input  logic [prc_pkg::IDX_W-1:0]         col_index_i,
  input  logic [prc_pkg::IDX_W-1:0]         other_row_i,
  input  logic                              cfg_we_i,
  input  logic [prc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [prc_pkg::LIM_W-1:0]         cfg_data_i,
  output prc_pkg::cmd_t                     cmd_o,
  input  prc_pkg::stat_t                    stat_i,
  output logic                              result_valid_o,
  output logic signed [prc_pkg::SMP_W-1:0]  correlation_o,
  output logic [1:0]                        status_o
);
  import prc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_VAR,
    S_MUL,
    S_DIV,
    S_SQRT
  } state_e;

  state_e state_q;
  logic   first_q;
  logic [LIM_W-1:0] cols_q, rows_q, row_lim, col_lim;
  logic   valid_q;
  logic signed [SMP_W-1:0] corr_q;
  status_e status_q;
  logic   accept, is_query, row_ok_a, row_ok_b, col_ok;

  // Effective limits and range checks on the incoming beat.
  always_comb begin
    row_lim  = (int'(rows_q) < MAX_ROWS) ? rows_q : LIM_W'(MAX_ROWS);
    col_lim  = (int'(cols_q) < MAX_COLS) ? cols_q : LIM_W'(MAX_COLS);
    accept   = start_i && (state_q == S_IDLE);
    is_query = (opcode_e'(opcode_i) == OPC_QUERY);
    row_ok_a = {1'b0, row_index_i} < row_lim;
    row_ok_b = {1'b0, other_row_i} < row_lim;
    col_ok   = {1'b0, col_index_i} < col_lim;
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o.we      = accept && !is_query && row_ok_a && col_ok;
    cmd_o.capture = accept && is_query;
    cmd_o.clr     = first_q;
    cmd_o.ncols   = col_lim;
    unique case (state_q)
      S_WALK:  cmd_o.op = DP_WALK;
      S_VAR:   cmd_o.op = DP_VAR;
      S_MUL:   cmd_o.op = DP_MUL;
      S_DIV:   cmd_o.op = DP_DIV;
      S_SQRT:  cmd_o.op = DP_SQRT;
      default: cmd_o.op = DP_IDLE;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= LIM_W'(64);
      rows_q <= LIM_W'(64);
    end else if (cfg_we_i) begin
      if (cfg_reg_e'(cfg_index_i) == CFG_COLS) cols_q <= cfg_data_i;
      if (cfg_reg_e'(cfg_index_i) == CFG_ROWS) rows_q <= cfg_data_i;
    end
  end

  // Phase sequencer and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      first_q  <= 1'b0;
      valid_q  <= 1'b0;
      corr_q   <= '0;
      status_q <= ST_OK;
    end else begin
      valid_q <= 1'b0;
      first_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept && is_query) begin
            if (!row_ok_a || !row_ok_b) begin
              valid_q  <= 1'b1;
              corr_q   <= '0;
              status_q <= ST_RANGE;
            end else if (row_index_i == other_row_i) begin
              valid_q  <= 1'b1;
              corr_q   <= SMP_W'(16'sh7FFF);
              status_q <= ST_OK;
            end else begin
              state_q <= S_WALK;
              first_q <= 1'b1;
            end
          end
        end
        S_WALK: begin
          if (stat_i.last) begin
            state_q <= S_VAR;
            first_q <= 1'b1;
          end
        end
        S_VAR: begin
          if (stat_i.last) begin
            if (stat_i.var_zero) begin
              valid_q  <= 1'b1;
              corr_q   <= '0;
              status_q <= ST_ZERO_VAR;
              state_q  <= S_IDLE;
            end else begin
              state_q <= S_MUL;
              first_q <= 1'b1;
            end
          end
        end
        S_MUL: begin
          if (stat_i.last) begin
            state_q <= S_DIV;
            first_q <= 1'b1;
          end
        end
        S_DIV: begin
          if (stat_i.last) begin
            state_q <= S_SQRT;
            first_q <= 1'b1;
          end
        end
        S_SQRT: begin
          if (stat_i.last) begin
            valid_q  <= 1'b1;
            corr_q   <= stat_i.corr;
            status_q <= ST_OK;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = valid_q;
  assign correlation_o  = corr_q;
  assign status_o       = status_q;

  // A load never yields a result beat.
  `PRC_ASSERT_NEXT(a_load_silent, accept && !is_query, !result_valid_o)
  // The memory is never written during a query.
  `PRC_ASSERT_NOW(a_no_write_busy, busy_o, !cmd_o.we)
  // Flagged results carry a zero coefficient.
  `PRC_ASSERT_NOW(a_flag_zero, result_valid_o && (status_o != ST_OK), correlation_o == '0)

endmodule

`default_nettype wire
